### rtl/xpd_pkg.sv
package xpd_pkg;

  // field widths
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CODE_W      = 56;
  localparam int unsigned ARGB_W      = 32;
  localparam int unsigned RGB_W       = 24;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CPP_W       = 3;
  localparam int unsigned PAL_SIZE_W  = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  // parameter defaults
  localparam int unsigned PALETTE_DEPTH_DEF  = 256;
  localparam int unsigned MAX_CODE_CHARS_DEF = 7;

  // colour constants
  localparam logic [ARGB_W-1:0] OPAQUE_ALPHA     = 32'hFF00_0000;
  localparam logic [ARGB_W-1:0] TRANSPARENT_ARGB = 32'h0000_0000;

  // image size limit
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // register reset values
  localparam logic [CPP_W-1:0]      CPP_RST      = 3'd1;
  localparam logic [PAL_SIZE_W-1:0] PAL_SIZE_RST = 9'd0;
  localparam logic [DIM_W-1:0]      WIDTH_RST    = 13'd64;
  localparam logic [DIM_W-1:0]      HEIGHT_RST   = 13'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHARS_PER_PIXEL = 2'd0,
    CFG_PALETTE_SIZE    = 2'd1,
    CFG_IMAGE_WIDTH     = 2'd2,
    CFG_IMAGE_HEIGHT    = 2'd3
  } xpd_cfg_idx_e;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } xpd_op_e;

  typedef struct packed {
    xpd_op_e             opcode;
    logic [SLOT_W-1:0]   entry_index;
    logic [CODE_W-1:0]   code_chars;
    logic [RGB_W-1:0]    color_rgb;
    logic                transparent;
  } xpd_in_t;

  typedef struct packed {
    logic [ARGB_W-1:0] pixel_argb;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic              last_pixel;
    logic              status;
  } xpd_out_t;

  // one beat travelling down the cell chain
  typedef struct packed {
    logic              valid;
    xpd_op_e           opcode;
    logic [SLOT_W-1:0] index;
    logic [CODE_W-1:0] code;
    logic [ARGB_W-1:0] data;
    logic              found;
  } xpd_beat_t;

endpackage

### rtl/xpd_cell.sv
module xpd_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned KeyW    = 56
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic [KeyW-1:0]                   mask_i,
  input  logic [xpd_pkg::PAL_SIZE_W-1:0]    palette_size_i,
  input  xpd_pkg::xpd_beat_t                beat_i,
  output xpd_pkg::xpd_beat_t                beat_o
);
  import xpd_pkg::*;

  logic [KeyW-1:0]   key_q;
  logic [ARGB_W-1:0] val_q;
  logic              match;
  logic              wr_hit;
  xpd_beat_t         beat_d;
  xpd_beat_t         beat_q;
  logic              valid_q;

  // compare against this slot, or claim a palette write for it
  always_comb begin
    match  = beat_i.valid && (beat_i.opcode == OP_PIXEL) && !beat_i.found &&
             (int'(CellIdx) < int'(palette_size_i)) &&
             (((key_q ^ beat_i.code[KeyW-1:0]) & mask_i) == '0);
    wr_hit = beat_i.valid && (beat_i.opcode == OP_PAL_WRITE) &&
             (int'(beat_i.index) == int'(CellIdx));
    beat_d = beat_i;
    if (match) begin
      beat_d.data  = val_q;
      beat_d.found = 1'b1;
    end
  end

  // palette slot held by this cell
  always_ff @(posedge clk_i) begin
    if (adv_i && wr_hit) begin
      key_q <= beat_i.code[KeyW-1:0];
      val_q <= beat_i.data;
    end
  end

  // beat register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= beat_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      beat_q <= beat_d;
    end
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

### rtl/xpd_out.sv
module xpd_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  xpd_pkg::xpd_beat_t            beat_i,
  input  logic [xpd_pkg::DIM_W-1:0]     image_width_i,
  input  logic [xpd_pkg::DIM_W-1:0]     image_height_i,
  output logic                          adv_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output xpd_pkg::xpd_out_t             out_data_o
);
  import xpd_pkg::*;

  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;
  logic             is_pixel;
  logic             col_wrap;
  logic             row_wrap;
  logic [POS_W-1:0] col_d, col_q;
  logic [POS_W-1:0] row_d, row_q;
  logic             valid_d, valid_q;
  xpd_out_t         res_d, res_q;

  // clamp image size to 1..4096
  always_comb begin
    if (image_width_i == '0) begin
      w = DIM_W'(1);
    end else if (image_width_i > MAX_DIM) begin
      w = MAX_DIM;
    end else begin
      w = image_width_i;
    end
    if (image_height_i == '0) begin
      h = DIM_W'(1);
    end else if (image_height_i > MAX_DIM) begin
      h = MAX_DIM;
    end else begin
      h = image_height_i;
    end
  end

  // chain moves whenever the output register is free or being drained
  assign adv_o    = !valid_q || out_ready_i;
  assign is_pixel = beat_i.valid && (beat_i.opcode == OP_PIXEL);

  // result and next position
  always_comb begin
    col_wrap = ({1'b0, col_q} + DIM_W'(1)) >= w;
    row_wrap = ({1'b0, row_q} + DIM_W'(1)) >= h;

    res_d.pixel_argb = beat_i.found ? beat_i.data : TRANSPARENT_ARGB;
    res_d.column     = col_q;
    res_d.row        = row_q;
    res_d.last_pixel = ({1'b0, col_q} == (w - DIM_W'(1))) &&
                       ({1'b0, row_q} == (h - DIM_W'(1)));
    res_d.status     = !beat_i.found;

    col_d   = col_q;
    row_d   = row_q;
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = is_pixel;
      if (is_pixel) begin
        if (col_wrap) begin
          col_d = '0;
          row_d = row_wrap ? '0 : row_q + POS_W'(1);
        end else begin
          col_d = col_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      valid_q <= valid_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && is_pixel) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

### rtl/xpm_palette_pixel_decoder_unit.sv
// datapath: a pixel's input beat passes the chain of palette cells, one slot per cell,
//   then the output register; all stall while its result is not taken
// throughput: one beat per cycle unless stalled; writes and pixels alike, in any mix
// reset: control state and pixel position clear at once; palette slots hold no
//   reset value and must be written before pixels are matched against them
module xpm_palette_pixel_decoder_unit #(
  parameter int unsigned PALETTE_DEPTH  = xpd_pkg::PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_CODE_CHARS = xpd_pkg::MAX_CODE_CHARS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  xpd_pkg::xpd_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output xpd_pkg::xpd_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [xpd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [xpd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import xpd_pkg::*;

  localparam int unsigned KeyW = MAX_CODE_CHARS * CHAR_W;

  logic [CPP_W-1:0]      cpp_q;
  logic [PAL_SIZE_W-1:0] pal_size_q;
  logic [DIM_W-1:0]      width_q;
  logic [DIM_W-1:0]      height_q;
  logic [CPP_W-1:0]      cpp_eff;
  logic [KeyW-1:0]       mask;
  logic                  adv;
  xpd_beat_t             chain [PALETTE_DEPTH+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpp_q      <= CPP_RST;
      pal_size_q <= PAL_SIZE_RST;
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (xpd_cfg_idx_e'(cfg_index_i))
        CFG_CHARS_PER_PIXEL: cpp_q      <= cfg_wdata_i[CPP_W-1:0];
        CFG_PALETTE_SIZE:    pal_size_q <= cfg_wdata_i[PAL_SIZE_W-1:0];
        CFG_IMAGE_WIDTH:     width_q    <= cfg_wdata_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:    height_q   <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // character mask from chars per pixel, clamped to 1..MAX_CODE_CHARS
  always_comb begin
    if (cpp_q == '0) begin
      cpp_eff = CPP_W'(1);
    end else if (int'(cpp_q) > int'(MAX_CODE_CHARS)) begin
      cpp_eff = CPP_W'(MAX_CODE_CHARS);
    end else begin
      cpp_eff = cpp_q;
    end
    for (int b = 0; b < int'(MAX_CODE_CHARS); b++) begin
      mask[b*CHAR_W +: CHAR_W] = (b < int'(cpp_eff)) ? '1 : '0;
    end
  end

  // input beat into the head of the chain
  assign in_ready_o = adv;

  always_comb begin
    chain[0].valid  = in_valid_i;
    chain[0].opcode = in_data_i.opcode;
    chain[0].index  = in_data_i.entry_index;
    chain[0].code   = in_data_i.code_chars;
    chain[0].found  = 1'b0;
    if (in_data_i.opcode == OP_PAL_WRITE) begin
      chain[0].data = in_data_i.transparent ? TRANSPARENT_ARGB
                                            : (OPAQUE_ALPHA | {8'h00, in_data_i.color_rgb});
    end else begin
      chain[0].data = TRANSPARENT_ARGB;
    end
  end

  // one cell per palette slot
  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    xpd_cell #(
      .CellIdx (k),
      .KeyW    (KeyW)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .adv_i          (adv),
      .mask_i         (mask),
      .palette_size_i (pal_size_q),
      .beat_i         (chain[k]),
      .beat_o         (chain[k+1])
    );
  end

  // output register and pixel position
  xpd_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (chain[PALETTE_DEPTH]),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .adv_o          (adv),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

endmodule

### tb/xpm_palette_pixel_decoder_unit_tb.sv
module xpm_palette_pixel_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xpd_pkg::*;

  localparam int DEPTH           = PALETTE_DEPTH_DEF;
  localparam int MAX_CHARS       = MAX_CODE_CHARS_DEF;
  localparam int STALL_LIMIT     = 4000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 200;
  localparam logic [CODE_W-1:0] ALL_CHARS = {CODE_W{1'b1}};

  // per-phase register settings: chars per pixel, palette size, width, height
  int ph_cpp[PHASES]    = '{1, 2, 7, 3, 0, 4, 5, 6, 7};
  int ph_size[PHASES]   = '{256, 100, 256, 511, 257, 1, 0, 64, 200};
  int ph_width[PHASES]  = '{16, 5, 4096, 1, 3, 8191, 7, 2, 13};
  int ph_height[PHASES] = '{8, 3, 4096, 1, 7, 2, 5, 8191, 1};

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  xpd_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  xpd_out_t out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  xpm_palette_pixel_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow of the palette, the position counters and the registers
  logic [CODE_W-1:0] pal_key  [DEPTH];
  logic [ARGB_W-1:0] pal_argb [DEPTH];
  logic [POS_W-1:0]  pos_col;
  logic [POS_W-1:0]  pos_row;
  logic [CPP_W-1:0]      cfg_cpp;
  logic [PAL_SIZE_W-1:0] cfg_size;
  logic [DIM_W-1:0]      cfg_width;
  logic [DIM_W-1:0]      cfg_height;

  xpd_out_t pending_pixels[$];
  int       err_cnt;
  int       gap_pct;
  bit       beats_sent;
  xpd_out_t seen_want;

  typedef struct {
    bit           is_reg;
    xpd_cfg_idx_e idx;
    logic [CFG_DATA_W-1:0] wdata;
    xpd_in_t      beat;
    bit           typed;
    xpd_out_t     want;
  } stim_row_t;

  stim_row_t directed[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > int'(MAX_DIM)) return int'(MAX_DIM);
    return int'(v);
  endfunction

  // bits of the code that take part in a match
  function automatic logic [CODE_W-1:0] char_mask();
    int n;
    logic [63:0] m;
    n = (cfg_cpp == 0) ? 1 : int'(cfg_cpp);
    if (n > MAX_CHARS) n = MAX_CHARS;
    m = (64'd1 << (n * CHAR_W)) - 64'd1;
    return m[CODE_W-1:0];
  endfunction

  function automatic int active_slots();
    return (int'(cfg_size) > DEPTH) ? DEPTH : int'(cfg_size);
  endfunction

  // palette write or pixel lookup with position advance
  task automatic decode_beat(input xpd_in_t beat, output bit has_pix, output xpd_out_t pix);
    logic [CODE_W-1:0] m;
    logic [ARGB_W-1:0] argb;
    bit found;
    int lim, w, h, col, row;
    has_pix = 1'b0;
    pix = '0;
    if (beat.opcode == OP_PAL_WRITE) begin
      if (int'(beat.entry_index) < DEPTH) begin
        pal_key[beat.entry_index]  = beat.code_chars;
        pal_argb[beat.entry_index] = beat.transparent ? TRANSPARENT_ARGB
                                                      : (OPAQUE_ALPHA | {8'h00, beat.color_rgb});
      end
    end else begin
      m = char_mask();
      lim = active_slots();
      found = 1'b0;
      argb = TRANSPARENT_ARGB;
      for (int i = 0; i < lim && !found; i++) begin
        if (((pal_key[i] ^ beat.code_chars) & m) == '0) begin
          found = 1'b1;
          argb = pal_argb[i];
        end
      end
      w = clamp_dim(cfg_width);
      h = clamp_dim(cfg_height);
      col = int'(pos_col);
      row = int'(pos_row);
      has_pix = 1'b1;
      pix.pixel_argb = argb;
      pix.column     = pos_col;
      pix.row        = pos_row;
      pix.last_pixel = (col == w - 1) && (row == h - 1);
      pix.status     = !found;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
      pos_col = col[POS_W-1:0];
      pos_row = row[POS_W-1:0];
    end
  endtask

  // short idle runs mostly, long ones now and then
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // key built from a small alphabet so that codes collide often
  function automatic logic [CODE_W-1:0] make_key();
    logic [CODE_W-1:0] k;
    for (int c = 0; c < MAX_CHARS; c++) begin
      if ($urandom_range(0, 3) == 0) k[c*CHAR_W +: CHAR_W] = CHAR_W'($urandom);
      else k[c*CHAR_W +: CHAR_W] = CHAR_W'(8'h61 + $urandom_range(0, 3));
    end
    return k;
  endfunction

  function automatic xpd_in_t random_beat(input bit write_only);
    xpd_in_t b;
    logic [63:0] noise;
    logic [CODE_W-1:0] m;
    int r, lim;
    noise = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    b.entry_index = SLOT_W'($urandom);
    b.color_rgb   = (r < 5) ? '0 : (r < 10) ? {RGB_W{1'b1}} : RGB_W'($urandom);
    b.transparent = ($urandom_range(0, 7) == 0);
    b.code_chars  = noise[CODE_W-1:0];
    r = $urandom_range(0, 99);
    if (write_only || r < 20) begin
      b.opcode = OP_PAL_WRITE;
      b.code_chars = make_key();
    end else begin
      b.opcode = OP_PIXEL;
      lim = active_slots();
      m = char_mask();
      if (lim > 0 && r < 80) begin
        // a live key, with the unused characters scrambled
        b.code_chars = (pal_key[$urandom_range(0, lim - 1)] & m) | (noise[CODE_W-1:0] & ~m);
      end else if (r < 90) begin
        b.code_chars = make_key();
      end
    end
    return b;
  endfunction

  function automatic xpd_in_t pal_beat(input logic [SLOT_W-1:0] slot,
                                       input logic [CODE_W-1:0] code,
                                       input logic [RGB_W-1:0] rgb, input logic clear);
    xpd_in_t b;
    b.opcode      = OP_PAL_WRITE;
    b.entry_index = slot;
    b.code_chars  = code;
    b.color_rgb   = rgb;
    b.transparent = clear;
    return b;
  endfunction

  function automatic xpd_in_t pixel_beat(input logic [CODE_W-1:0] code);
    xpd_in_t b;
    b.opcode      = OP_PIXEL;
    b.entry_index = {SLOT_W{1'b1}};
    b.code_chars  = code;
    b.color_rgb   = {RGB_W{1'b1}};
    b.transparent = 1'b1;
    return b;
  endfunction

  function automatic xpd_out_t px_out(input logic [ARGB_W-1:0] argb, input int col,
                                      input int row, input logic last, input logic st);
    xpd_out_t o;
    o.pixel_argb = argb;
    o.column     = col[POS_W-1:0];
    o.row        = row[POS_W-1:0];
    o.last_pixel = last;
    o.status     = st;
    return o;
  endfunction

  task automatic add_reg(input xpd_cfg_idx_e idx, input int val);
    stim_row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.wdata  = val[CFG_DATA_W-1:0];
    r.beat   = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    directed.push_back(r);
  endtask

  task automatic add_beat(input xpd_in_t beat, input bit typed = 1'b0,
                          input xpd_out_t want = '0);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.idx    = CFG_CHARS_PER_PIXEL;
    r.wdata  = '0;
    r.beat   = beat;
    r.typed  = typed;
    r.want   = want;
    directed.push_back(r);
  endtask

  // input beat: optional gap, then hold valid until taken
  task automatic send_beat(input xpd_in_t beat);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= beat;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent = 1'b1;
  endtask

  task automatic issue(input xpd_in_t beat, input bit typed, input xpd_out_t want);
    bit has_pix;
    xpd_out_t pix;
    send_beat(beat);
    decode_beat(beat, has_pix, pix);
    if (has_pix) pending_pixels.push_back(typed ? want : pix);
  endtask

  // wait for every pixel, then let queued palette writes leave the cell chain
  task automatic drain();
    in_valid_i <= 1'b0;
    if (beats_sent) begin
      while (pending_pixels.size() != 0) @(negedge clk_i);
      repeat (DEPTH + 8) @(negedge clk_i);
      beats_sent = 1'b0;
    end
  endtask

  task automatic write_reg(input xpd_cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_CHARS_PER_PIXEL: cfg_cpp    = val[CPP_W-1:0];
      CFG_PALETTE_SIZE:    cfg_size   = val[PAL_SIZE_W-1:0];
      CFG_IMAGE_WIDTH:     cfg_width  = val[DIM_W-1:0];
      default:             cfg_height = val[DIM_W-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic note_error(input string what, input xpd_out_t want, input xpd_out_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s: want %h/%0d/%0d/%b/%b, got %h/%0d/%0d/%b/%b",
               what, want.pixel_argb, want.column, want.row, want.last_pixel, want.status,
               got.pixel_argb, got.column, got.row, got.last_pixel, got.status);
    end
  endtask

  // output side: ready runs and stalls
  initial begin : ready_gen
    int run;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      out_ready_i <= 1'b1;
      repeat (run) @(negedge clk_i);
      out_ready_i <= 1'b0;
      repeat (idle_len()) @(negedge clk_i);
    end
  end

  // result beats against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        note_error("unexpected pixel", '0, out_data_o);
      end else begin
        seen_want = pending_pixels.pop_front();
        if (out_data_o.pixel_argb !== seen_want.pixel_argb ||
            out_data_o.column     !== seen_want.column     ||
            out_data_o.row        !== seen_want.row        ||
            out_data_o.last_pixel !== seen_want.last_pixel ||
            out_data_o.status     !== seen_want.status) begin
          note_error("pixel mismatch", seen_want, out_data_o);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("xpm_palette_pixel_decoder_unit test failed");
    $finish;
  end

  initial begin
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_CHARS_PER_PIXEL;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    err_cnt     = 0;
    beats_sent  = 1'b0;
    gap_pct     = 20;
    pos_col     = '0;
    pos_row     = '0;
    cfg_cpp     = CPP_RST;
    cfg_size    = PAL_SIZE_RST;
    cfg_width   = WIDTH_RST;
    cfg_height  = HEIGHT_RST;
    for (int s = 0; s < DEPTH; s++) begin
      pal_key[s]  = '0;
      pal_argb[s] = '0;
    end

    // directed rows: reset values, wrap past a shrunk size, masking, duplicates
    add_beat(pixel_beat('0), 1'b1, px_out(TRANSPARENT_ARGB, 0, 0, 1'b0, 1'b1));
    add_beat(pixel_beat(ALL_CHARS), 1'b1, px_out(TRANSPARENT_ARGB, 1, 0, 1'b0, 1'b1));
    add_reg(CFG_IMAGE_WIDTH, 2);
    add_reg(CFG_IMAGE_HEIGHT, 2);
    add_beat(pal_beat(8'd0, 56'h41, 24'hFF_FFFF, 1'b0));
    add_beat(pal_beat(8'd1, 56'h41, 24'h12_3456, 1'b0));
    add_beat(pal_beat(8'd2, 56'h42, 24'hAB_CDEF, 1'b1));
    add_beat(pal_beat(8'd3, ALL_CHARS, 24'h00_0000, 1'b0));
    add_beat(pal_beat(8'd255, 56'h0, 24'hFF_FFFF, 1'b1));
    add_reg(CFG_PALETTE_SIZE, 4);
    add_beat(pixel_beat(56'h41));
    add_beat(pixel_beat(56'h42));
    add_beat(pixel_beat(ALL_CHARS));
    add_beat(pixel_beat(56'h43));
    add_beat(pixel_beat(56'hAB_CD41));
    add_reg(CFG_CHARS_PER_PIXEL, 7);
    add_beat(pixel_beat(56'hAB_CD41));
    add_beat(pixel_beat(56'h41));
    add_beat(pixel_beat(ALL_CHARS));
    add_reg(CFG_CHARS_PER_PIXEL, 0);
    add_beat(pixel_beat(56'h1142));
    add_reg(CFG_IMAGE_WIDTH, 0);
    add_reg(CFG_IMAGE_HEIGHT, 0);
    add_beat(pixel_beat(56'h41));
    add_beat(pixel_beat(56'h41), 1'b1, px_out(OPAQUE_ALPHA | 32'hFF_FFFF, 0, 0, 1'b1, 1'b0));
    add_beat(pixel_beat(56'h44), 1'b1, px_out(TRANSPARENT_ARGB, 0, 0, 1'b1, 1'b1));
    add_reg(CFG_IMAGE_WIDTH, 4096);
    add_reg(CFG_IMAGE_HEIGHT, 8191);
    add_beat(pixel_beat(56'h42));

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        drain();
        write_reg(directed[i].idx, directed[i].wdata);
      end else begin
        issue(directed[i].beat, directed[i].typed, directed[i].want);
      end
    end

    // fill every slot so any palette size is safe to search
    for (int s = 0; s < DEPTH; s++) begin
      xpd_in_t fill;
      fill = random_beat(1'b1);
      fill.entry_index = s[SLOT_W-1:0];
      issue(fill, 1'b0, '0);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_CHARS_PER_PIXEL, ph_cpp[p][CFG_DATA_W-1:0]);
      write_reg(CFG_PALETTE_SIZE, ph_size[p][CFG_DATA_W-1:0]);
      write_reg(CFG_IMAGE_WIDTH, ph_width[p][CFG_DATA_W-1:0]);
      write_reg(CFG_IMAGE_HEIGHT, ph_height[p][CFG_DATA_W-1:0]);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        issue(random_beat(1'b0), 1'b0, '0);
      end
    end

    drain();
    if (pending_pixels.size() != 0) begin
      $display("pixels never delivered: %0d", pending_pixels.size());
      err_cnt += pending_pixels.size();
    end
    if (err_cnt == 0) begin
      $display("xpm_palette_pixel_decoder_unit test passed");
    end else begin
      $display("xpm_palette_pixel_decoder_unit test failed");
    end
    $finish;
  end

endmodule

### xpm_palette_pixel_decoder_unit.f
rtl/xpd_pkg.sv
rtl/xpd_cell.sv
rtl/xpd_out.sv
rtl/xpm_palette_pixel_decoder_unit.sv
tb/xpm_palette_pixel_decoder_unit_tb.sv
